// ===== rtl/core/pip_pkg.sv =====
// Shared constants and interface types of the point-in-polygon crossing-number block.
package pip_pkg;

  localparam int DefMaxVertices  = 64;
  localparam int DefCoordWidth   = 32;
  localparam int MinPolyVertices = 3;
  localparam int CountWidth      = 7;
  localparam int IndexWidth      = 6;

  typedef enum logic {
    ModeWrite = 1'b0,
    ModeQuery = 1'b1
  } mode_e;

  // sequencer -> edge unit
  typedef struct packed {
    logic clear;  // start of a query: drop the parity flag
    logic vld;    // vertex read data valid this cycle
    logic first;  // this vertex only seeds the previous-vertex register
  } edge_ctl_t;

  // edge unit -> sequencer
  typedef struct packed {
    logic busy;
    logic parity;
  } edge_sts_t;

endpackage

// ===== rtl/core/pip_edge_unit.sv =====
// Pipelined edge crossing test and parity accumulation for one query.
module pip_edge_unit import pip_pkg::*; #(
  parameter int COORD_WIDTH = DefCoordWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  edge_ctl_t                     ctl_i,
  input  logic signed [COORD_WIDTH-1:0] vx_i,
  input  logic signed [COORD_WIDTH-1:0] vy_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output edge_sts_t                     sts_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] bx_q, by_q;

  logic                 s1_vld_q, s1_str_q, s1_dneg_q;
  logic signed [DW-1:0] s1_dxp_q, s1_dy_q, s1_dxb_q, s1_dyp_q;
  logic signed [DW-1:0] dxp_d, dy_d, dxb_d, dyp_d;
  logic                 str_d;

  logic                 s2_vld_q, s2_str_q, s2_dneg_q;
  logic signed [PW-1:0] p_q, q_q;
  logic                 crosses;
  logic                 inside_q;

  // stage 1: straddle check and coordinate differences (a = current, b = previous)
  always_comb begin
    str_d = (vy_i > py_i) != (by_q > py_i);
    dxp_d = {px_i[COORD_WIDTH-1], px_i} - {vx_i[COORD_WIDTH-1], vx_i};
    dy_d  = {by_q[COORD_WIDTH-1], by_q} - {vy_i[COORD_WIDTH-1], vy_i};
    dxb_d = {bx_q[COORD_WIDTH-1], bx_q} - {vx_i[COORD_WIDTH-1], vx_i};
    dyp_d = {py_i[COORD_WIDTH-1], py_i} - {vy_i[COORD_WIDTH-1], vy_i};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.vld) begin
      bx_q <= vx_i;
      by_q <= vy_i;
    end
    s1_str_q  <= str_d;
    s1_dneg_q <= dy_d[DW-1];
    s1_dxp_q  <= dxp_d;
    s1_dy_q   <= dy_d;
    s1_dxb_q  <= dxb_d;
    s1_dyp_q  <= dyp_d;
    // stage 2: full-width products of the cross-multiplied compare
    s2_str_q  <= s1_str_q;
    s2_dneg_q <= s1_dneg_q;
    p_q       <= s1_dxp_q * s1_dy_q;
    q_q       <= s1_dxb_q * s1_dyp_q;
  end

  // dy is never zero on a straddling edge; negative dy flips the compare
  assign crosses = s2_dneg_q ? (p_q > q_q) : (p_q < q_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      s1_vld_q <= ctl_i.vld && !ctl_i.first;
      s2_vld_q <= s1_vld_q;
      if (ctl_i.clear) begin
        inside_q <= 1'b0;
      end else if (s2_vld_q && s2_str_q && crosses) begin
        inside_q <= !inside_q;
      end
    end
  end

  assign sts_o.busy   = s1_vld_q || s2_vld_q;
  assign sts_o.parity = inside_q;

endmodule

// ===== rtl/core/point_in_polygon_test.sv =====
// Top level: vertex memory, query sequencer and result register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------------------
//  in       | in_valid_i / in_ready_o  | mode_i, vertex_index_i, coord_x_i, coord_y_i
//  out      | out_valid_o / out_ready_i| inside_res_o
//  cfg      | cfg_we_i                 | cfg_wdata_i (vertex_count)
//
// A vertex write gives no result. A query with n >= 3 vertices reads the vertex
// memory once per cycle (n + 1 reads, one port) and then drains the edge pipeline.
// A query on fewer than three vertices reads no vertex and goes straight to the
// drain state. One query is in flight at a time; a result waiting in the output
// register holds the next query in its drain state, and input waits until that
// result is taken.
// Reset clears control state and vertex_count; the memory itself is not cleared.
module point_in_polygon_test import pip_pkg::*; #(
  parameter int MAX_VERTICES = DefMaxVertices,
  parameter int COORD_WIDTH  = DefCoordWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CountWidth-1:0]         cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [IndexWidth-1:0]         vertex_index_i,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          inside_res_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CountWidth-1:0] vertex_count_q;
  logic [NW-1:0]         n_cfg;
  logic                  small_poly;
  logic [AW-1:0]         cnt_q, cnt_d, last_q;
  logic signed [COORD_WIDTH-1:0] px_q, py_q;

  logic in_acc, wr_en, qry, rd_en, out_load;
  logic rd_vld_q, rd_first_q;
  logic [AW-1:0] rd_addr;
  logic [2*COORD_WIDTH-1:0] mem [MAX_VERTICES];
  logic [2*COORD_WIDTH-1:0] rd_data_q;
  logic out_valid_q, inside_q;

  edge_ctl_t ctl;
  edge_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (32'(vertex_count_q) > MAX_VERTICES) begin
      n_cfg = NW'(MAX_VERTICES);
    end else begin
      n_cfg = NW'(vertex_count_q);
    end
  end
  assign small_poly = n_cfg < NW'(MinPolyVertices);

  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign wr_en      = in_acc && (mode_i == ModeWrite) && (32'(vertex_index_i) < MAX_VERTICES);
  assign qry        = in_acc && (mode_i == ModeQuery);

  // first read fetches the last vertex to close the polygon
  assign rd_en   = (qry && !small_poly) || (state_q == S_RUN);
  assign rd_addr = (state_q == S_RUN) ? cnt_q : AW'(n_cfg - NW'(1));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(vertex_index_i)] <= {coord_x_i, coord_y_i};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    if (qry) begin
      px_q   <= coord_x_i;
      py_q   <= coord_y_i;
      last_q <= AW'(n_cfg - NW'(1));
    end
  end

  assign out_load = (state_q == S_DRAIN) && !rd_vld_q && !sts.busy
                    && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (qry) begin
          cnt_d   = '0;
          state_d = small_poly ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == last_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_first_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_en;
      rd_first_q <= qry;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      inside_q <= sts.parity;
    end
  end

  assign ctl.clear = qry;
  assign ctl.vld   = rd_vld_q;
  assign ctl.first = rd_first_q;

  pip_edge_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_edge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .vx_i   (rd_data_q[2*COORD_WIDTH-1:COORD_WIDTH]),
    .vy_i   (rd_data_q[COORD_WIDTH-1:0]),
    .px_i   (px_q),
    .py_i   (py_q),
    .sts_o  (sts)
  );

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  // read counter never walks past the last vertex
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (cnt_q <= last_q))
    else $error("vertex read counter past last vertex");

  // result is taken only once the edge pipeline has drained
  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!rd_vld_q && !sts.busy))
    else $error("result loaded with edges in flight");

  // a degenerate polygon never touches the memory
  a_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qry && small_poly) |=> (state_q == S_DRAIN && !rd_vld_q))
    else $error("small polygon started a vertex walk");

  // vertex reads happen only for a query in progress
  a_no_rd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && !rd_first_q) |-> (state_q != S_IDLE))
    else $error("vertex read outside a query");

endmodule
